// ===== rtl/rgb_rainbow_fader_unit_assert.svh =====
// Assertion macros for the rainbow fader unit.
// Used by rgb_rainbow_fader_unit.sv; expects signals clock and reset in scope.
`ifndef RGB_RAINBOW_FADER_UNIT_ASSERT_SVH
`define RGB_RAINBOW_FADER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RRF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rrf assertion failed");

// next-cycle implication
`define RRF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rrf assertion failed");

`endif

// ===== rtl/rrf_pkg.sv =====
// Package for the rainbow fader unit: widths, register indexes, reset values.
// No dependencies; used by rrf_step.sv and rgb_rainbow_fader_unit.sv.
`timescale 1ns / 1ps

package rrf_pkg;

   localparam int LEVEL_WIDTH_DEF = 16;   // Q8.8 levels by default
   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int TIME_WIDTH      = 16;   // Q0.16
   localparam int OUT_WIDTH       = 16;   // per-channel output field
   localparam int REQ_TDATA_WIDTH = TIME_WIDTH;
   localparam int RSP_TDATA_WIDTH = 3 * OUT_WIDTH;
   localparam int CHAN_WIDTH      = 2;

   localparam logic [CSR_WIDTH-1:0] HIGH_RESET  = 16'hFF00;
   localparam logic [CSR_WIDTH-1:0] LOW_RESET   = 16'h0000;
   localparam logic [CSR_WIDTH-1:0] SPEED_RESET = 16'h0A00;   // 10.0

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEVEL_HIGH = 2'd0,
      CSR_LEVEL_LOW  = 2'd1,
      CSR_FADE_SPEED = 2'd2
   } csr_index_type;

   typedef logic [CHAN_WIDTH-1:0] chan_type;
   localparam chan_type CH_RED   = 2'd0;
   localparam chan_type CH_GREEN = 2'd1;
   localparam chan_type CH_BLUE  = 2'd2;

endpackage

// ===== rtl/rgb_rainbow_fader_unit.sv =====
// Rainbow fader unit: one result word per time-step word.
// Depends on rrf_pkg, rrf_step and rgb_rainbow_fader_unit_assert.svh.
//
// Each req word carries a time step; the unit forms d = fade_speed * time_step
// (Q8.8) and moves the active channel against its partner, giving a
// red -> blue -> green -> red cycle; every step returns all three levels.
// The path holds two registers (input register, then result register). A word can
// be taken every cycle: the step logic (one 16x16 multiply at the default
// width, then compares and clamps) sits between the input register and the
// result/state registers, and the channel state updates in the same cycle
// the result is loaded, so back-to-back steps see the fresh levels. rsp
// back-pressure holds the result register and, one word later, stalls req.
// CSR writes (level_high, level_low, fade_speed) act on the next step and
// do not reload the levels; write them only while the unit is idle.
`timescale 1ns / 1ps
`include "rgb_rainbow_fader_unit_assert.svh"

module rgb_rainbow_fader_unit #(
   parameter int LEVEL_WIDTH = rrf_pkg::LEVEL_WIDTH_DEF   // 8..32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // config write port
   input  logic                                   csr_we,
   input  logic [rrf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [rrf_pkg::CSR_WIDTH-1:0]          csr_wdata,
   // step words in
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [rrf_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,   // [15:0] time_step
   // level words out
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rrf_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata    // [15:0] red_level,
                                                               // [31:16] green_level,
                                                               // [47:32] blue_level
);
   import rrf_pkg::*;

   localparam int RW = (LEVEL_WIDTH > OUT_WIDTH) ? LEVEL_WIDTH : OUT_WIDTH;
   localparam logic [LEVEL_WIDTH-1:0] LVL_MAX = LEVEL_WIDTH'(255) << (LEVEL_WIDTH - 8);

   // config registers
   logic [CSR_WIDTH-1:0] high_ff, low_ff, speed_ff;

   // input stage
   logic                  s1_valid_ff;
   logic [TIME_WIDTH-1:0] s1_time_ff;

   // channel state
   logic [LEVEL_WIDTH-1:0] lvl_ff [3];
   logic [LEVEL_WIDTH-1:0] lvl_in [3];
   chan_type               act_ff, act_in;

   // result stage
   logic                       rsp_valid_ff;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic step_fire;
   logic [RW-1:0] out_ext [3];

   assign step_fire  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || step_fire;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rrf_step #(
      .LEVEL_WIDTH (LEVEL_WIDTH)
   ) u_step (
      .level_high (high_ff),
      .level_low  (low_ff),
      .fade_speed (speed_ff),
      .time_step  (s1_time_ff),
      .lvl_cur    (lvl_ff),
      .act_cur    (act_ff),
      .lvl_nxt    (lvl_in),
      .act_nxt    (act_in)
   );

   // outputs are the low 16 bits of each level
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_ext[i] = RW'(lvl_in[i]);
      end
      rsp_data_in = {out_ext[2][OUT_WIDTH-1:0], out_ext[1][OUT_WIDTH-1:0],
                     out_ext[0][OUT_WIDTH-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= HIGH_RESET;
         low_ff   <= LOW_RESET;
         speed_ff <= SPEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_HIGH: high_ff  <= csr_wdata;
            CSR_LEVEL_LOW:  low_ff   <= csr_wdata;
            CSR_FADE_SPEED: speed_ff <= csr_wdata;
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lvl_ff[0]    <= LVL_MAX;
         lvl_ff[1]    <= '0;
         lvl_ff[2]    <= '0;
         act_ff       <= CH_RED;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (step_fire) begin
            rsp_valid_ff <= 1'b1;
            lvl_ff       <= lvl_in;
            act_ff       <= act_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_time_ff <= req_tdata[TIME_WIDTH-1:0];
      end
      if (step_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a step always leaves a result behind
   `RRF_ASSERT_NEXT(a_step_gives_rsp, step_fire, rsp_valid_ff)
   // channel state moves only on a step
   `RRF_ASSERT_NEXT(a_state_only_on_step, !step_fire,
      $stable(act_ff) && $stable(lvl_ff[0]) && $stable(lvl_ff[1]) && $stable(lvl_ff[2]))
   // active channel never takes the unused code
   `RRF_ASSERT_NOW(a_act_legal, 1'b1, act_ff != 2'd3)

endmodule

// ===== rtl/rrf_step.sv =====
// One fade step: bound sanitizing, d = speed * time, active/partner update.
// Depends on rrf_pkg. Purely combinational; the caller registers the result.
`timescale 1ns / 1ps

module rrf_step #(
   parameter int LEVEL_WIDTH = rrf_pkg::LEVEL_WIDTH_DEF
) (
   input  logic [rrf_pkg::CSR_WIDTH-1:0]  level_high,
   input  logic [rrf_pkg::CSR_WIDTH-1:0]  level_low,
   input  logic [rrf_pkg::CSR_WIDTH-1:0]  fade_speed,
   input  logic [rrf_pkg::TIME_WIDTH-1:0] time_step,
   input  logic [LEVEL_WIDTH-1:0]         lvl_cur [3],
   input  rrf_pkg::chan_type              act_cur,
   output logic [LEVEL_WIDTH-1:0]         lvl_nxt [3],
   output rrf_pkg::chan_type              act_nxt
);
   import rrf_pkg::*;

   localparam int RW = (LEVEL_WIDTH > CSR_WIDTH) ? LEVEL_WIDTH : CSR_WIDTH;
   localparam int PW = LEVEL_WIDTH + TIME_WIDTH;
   localparam logic [LEVEL_WIDTH-1:0] LVL_MAX = LEVEL_WIDTH'(255) << (LEVEL_WIDTH - 8);

   logic [RW-1:0]          high_ext, low_ext, speed_ext;
   logic [LEVEL_WIDTH-1:0] h_raw, l_raw, h_clip, lo, hi, speed, d;
   logic [PW-1:0]          prod;
   chan_type               a, p;
   logic [LEVEL_WIDTH-1:0] cur, nxt, cur1, cur2, cur4, nxt3;
   logic [LEVEL_WIDTH:0]   cur3, nxt2;
   logic                   turn;

   always_comb begin
      // bounds, masked to the level width
      high_ext  = RW'(level_high);
      low_ext   = RW'(level_low);
      speed_ext = RW'(fade_speed);
      h_raw     = high_ext[LEVEL_WIDTH-1:0];
      l_raw     = low_ext[LEVEL_WIDTH-1:0];
      speed     = speed_ext[LEVEL_WIDTH-1:0];
      h_clip    = (h_raw > LVL_MAX) ? LVL_MAX : h_raw;
      lo        = (l_raw >= h_clip) ? '0 : l_raw;
      hi        = (h_clip <= lo) ? LVL_MAX : h_clip;

      prod = PW'(speed) * PW'(time_step);
      d    = prod[PW-1:TIME_WIDTH];

      // a stray code 3 behaves as red
      a = (act_cur > CH_BLUE) ? CH_RED : act_cur;
      unique case (a)
         CH_RED:   p = CH_BLUE;
         CH_GREEN: p = CH_RED;
         default:  p = CH_GREEN;
      endcase

      cur = lvl_cur[a];
      nxt = lvl_cur[p];

      cur1 = (cur <= nxt) ? ((cur >= d) ? cur - d : '0) : cur;
      cur2 = (cur1 <= lo) ? lo : cur1;
      cur3 = (cur2 < hi && nxt < hi) ? {1'b0, cur2} + {1'b0, d} : {1'b0, cur2};
      cur4 = (cur3 >= {1'b0, hi}) ? hi : cur3[LEVEL_WIDTH-1:0];
      nxt2 = (cur4 == hi) ? {1'b0, nxt} + {1'b0, d} : {1'b0, nxt};
      nxt3 = (nxt2 >= {1'b0, hi}) ? hi : nxt2[LEVEL_WIDTH-1:0];
      turn = (nxt3 == hi) && (cur4 == lo);

      lvl_nxt    = lvl_cur;
      lvl_nxt[a] = cur4;
      lvl_nxt[p] = nxt3;
      act_nxt    = turn ? p : a;
   end

endmodule

// ===== tb/tb_rgb_rainbow_fader_unit.sv =====
// Self-checking testbench for rgb_rainbow_fader_unit: time-step words in, level words out.
// Depends on rrf_pkg and the RTL of rgb_rainbow_fader_unit only; stands alone.
`timescale 1ns / 1ps

module tb_rgb_rainbow_fader_unit;
   import rrf_pkg::*;

   localparam int                   CLOCK_HALF   = 5;
   localparam int                   STALL_LIMIT  = 4000;  // cycles with no word moving
   localparam int                   HOLD_CYCLES  = 80;    // long receiver hold-off
   localparam int                   DRAIN_CYCLES = 4;     // pipeline depth plus margin
   localparam logic [31:0]          LEVEL_MAX    = 32'd65280;   // 255.0 in Q8.8
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;     // unmapped index

   typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_mode_type;

   // ---------------------------------------------------------------------------
   // Level predictor and queue of expected level words
   // ---------------------------------------------------------------------------
   class fade_scoreboard;
      logic [CSR_WIDTH-1:0] level_high;
      logic [CSR_WIDTH-1:0] level_low;
      logic [CSR_WIDTH-1:0] fade_speed;
      logic [15:0]          levels[3];
      chan_type             active;
      logic [47:0]          expected_levels[$];
      int                   errors;
      int                   steps;
      int                   checked;
      int                   handovers;

      function new();
         level_high = HIGH_RESET;
         level_low  = LOW_RESET;
         fade_speed = SPEED_RESET;
         levels[0]  = 16'hFF00;
         levels[1]  = 16'h0000;
         levels[2]  = 16'h0000;
         active     = CH_RED;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_WIDTH-1:0] val);
         case (idx)
            CSR_LEVEL_HIGH: level_high = val;
            CSR_LEVEL_LOW:  level_low  = val;
            CSR_FADE_SPEED: fade_speed = val;
            default: ;   // unmapped index, write dropped
         endcase
      endfunction

      // one accepted time step: advance the fade and queue the three levels
      function void note_step(logic [15:0] time_step);
         logic [31:0] hi, lo, d, cur, nxt;
         chan_type    partner;
         hi = 32'(level_high);
         lo = 32'(level_low);
         if (hi > LEVEL_MAX) hi = LEVEL_MAX;
         if (lo >= hi) lo = 0;
         if (hi <= lo) hi = LEVEL_MAX;
         d = (32'(fade_speed) * 32'(time_step)) >> 16;
         partner = (active == CH_RED) ? CH_BLUE : ((active == CH_GREEN) ? CH_RED : CH_GREEN);
         cur = 32'(levels[active]);
         nxt = 32'(levels[partner]);
         if (cur <= nxt) cur = (cur >= d) ? cur - d : 32'd0;
         if (cur <= lo) cur = lo;
         if (cur < hi && nxt < hi) cur = cur + d;
         if (cur >= hi) cur = hi;
         if (cur == hi) nxt = nxt + d;
         if (nxt >= hi) nxt = hi;
         levels[active]  = cur[15:0];
         levels[partner] = nxt[15:0];
         if (nxt == hi && cur == lo) begin
            active = partner;
            handovers++;
         end
         expected_levels.push_back({levels[2], levels[1], levels[0]});
         steps++;
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("%0t ns  mismatch: %s", $realtime, msg);
      endtask

      task check_levels(logic [47:0] got);
         logic [47:0] want;
         if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("level word %h with nothing expected", got));
         end else begin
            want = expected_levels.pop_front();
            checked++;
            if (got[15:0] !== want[15:0])
               report_mismatch($sformatf("red %h, expected %h", got[15:0], want[15:0]));
            if (got[31:16] !== want[31:16])
               report_mismatch($sformatf("green %h, expected %h", got[31:16], want[31:16]));
            if (got[47:32] !== want[47:32])
               report_mismatch($sformatf("blue %h, expected %h", got[47:32], want[47:32]));
         end
      endtask

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Signals; every input known from time zero
   // ---------------------------------------------------------------------------
   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         csr_we     = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index  = '0;
   logic [CSR_WIDTH-1:0]         csr_wdata  = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_TDATA_WIDTH-1:0]   req_tdata  = '0;   // [15:0] time_step
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata;         // [15:0] red, [31:16] green, [47:32] blue

   fade_scoreboard sb = new();

   int   src_idle_pct  = 0;
   int   snk_stall_pct = 0;
   bit   hold_request  = 1'b0;
   int   hold_left     = 0;
   int   idle_cycles   = 0;
   int   bound_sets    = 0;

   rgb_rainbow_fader_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted here on request
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // result monitor: sampled at the rising edge, pre-update values
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_levels(rsp_tdata);
   end

   // watchdog: any accepted word on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: %0d cycles without a word moving", idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // Driver tasks; all of them start and end just after a falling edge
   // ---------------------------------------------------------------------------
   task automatic set_flow(flow_mode_type mode);
      case (mode)
         FLOW_FREE:      begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         FLOW_SRC_IDLE:  begin src_idle_pct = 77; snk_stall_pct = 0;  end
         FLOW_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 77; end
         FLOW_BOTH:      begin src_idle_pct = 36; snk_stall_pct = 36; end
      endcase
   endtask

   // offer one time-step word, with random gaps ahead of it
   task automatic send_step(logic [15:0] time_step);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= time_step;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_step(time_step);
      @(negedge clock);
   endtask

   // sender pause: hold valid low until every level word is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // new bounds and speed, written only with the pipe empty; spare index gets junk
   task automatic apply_bounds(logic [15:0] high, logic [15:0] low, logic [15:0] speed);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_LEVEL_HIGH;
      csr_wdata <= high;
      @(negedge clock);
      csr_index <= CSR_LEVEL_LOW;
      csr_wdata <= low;
      @(negedge clock);
      csr_index <= CSR_FADE_SPEED;
      csr_wdata <= speed;
      @(negedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom);
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.set_register(CSR_LEVEL_HIGH, high);
      sb.set_register(CSR_LEVEL_LOW, low);
      sb.set_register(CSR_FADE_SPEED, speed);
      bound_sets++;
      @(negedge clock);
   endtask

   // random phase; hold_at / drain_at pick the word before which pressure is applied
   task automatic run_phase(logic [15:0] high, logic [15:0] low, logic [15:0] speed,
                            flow_mode_type mode, int count, int hold_at, int drain_at);
      logic [15:0] time_step;
      apply_bounds(high, low, speed);
      set_flow(mode);
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) begin
            // drop the last word first so the wait below cannot resend it;
            // request the hold-off at a rising edge, the receiver takes it at the fall
            req_tvalid <= 1'b0;
            @(posedge clock);
            hold_request = 1'b1;
            @(negedge clock);
         end
         if (n == drain_at)
            wait_drained();
         case ($urandom_range(3))
            0:       time_step = 16'($urandom_range(255));            // slow creep
            1:       time_step = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: time_step = 16'($urandom);
         endcase
         send_step(time_step);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [15:0] warmup_steps[8];
      logic [15:0] sprint_steps[12];
      warmup_steps = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                       16'h0100, 16'h7FFF, 16'hAAAA, 16'h5555};
      sprint_steps = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'h0000, 16'h0001, 16'h4000, 16'hC000, 16'hFFFF};

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset bounds, extremes of the time step
      set_flow(FLOW_FREE);
      foreach (warmup_steps[i]) send_step(warmup_steps[i]);

      // directed: full speed, repeated full steps hand the active channel over
      apply_bounds(16'hFF00, 16'h0000, 16'hFFFF);
      foreach (sprint_steps[i]) send_step(sprint_steps[i]);

      // high above max and low >= high: high clamps to max, low falls to zero;
      // long receiver hold-off while the sender keeps pushing
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, FLOW_FREE, 90, 30, -1);
      // high of zero: low >= high clears low, then high <= low restores max
      run_phase(16'h0000, 16'h0000, 16'd40000, FLOW_SRC_IDLE, 90, -1, -1);
      // band shrinks under levels already at max: clamps of the normal step only;
      // sender pauses mid-phase until everything is back
      run_phase(16'h8000, 16'h2000, 16'd12000, FLOW_SNK_STALL, 90, -1, 40);
      // narrow band right above the bottom
      run_phase(16'h0100, 16'h00FF, 16'hFFFF, FLOW_BOTH, 90, -1, -1);
      // zero speed: nothing moves except out-of-band levels pulled in by clamps
      run_phase(16'h6000, 16'h6000, 16'h0000, FLOW_SNK_STALL, 40, -1, -1);
      run_phase(HIGH_RESET, 16'h1000, 16'd3000, FLOW_BOTH, 90, -1, -1);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d time steps over %0d bound settings; %0d level words checked,",
               sb.steps, bound_sets + 1, sb.checked);
      $display("%0d channel hand-overs, %0d mismatches.", sb.handovers, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
